// ===== design/sdrx_pkg.sv =====
// Package: shared types, codes and the CRC-16 byte update for the SD block receiver.
`default_nettype none

package sdrx_pkg;

   // Start token that opens a data block
   localparam logic [7:0]  START_TOKEN = 8'hFE;
   // CRC-16 polynomial (x^16 + x^12 + x^5 + 1)
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   // Largest block length honoured; longer settings saturate here
   localparam logic [9:0]  MAX_BLOCK   = 10'd512;

   // Register reset values
   localparam logic [9:0]  BLOCK_LENGTH_RESET = 10'd512;
   localparam logic [15:0] TOKEN_TRIES_RESET  = 16'd20000;

   // Register indexes on the configuration port
   localparam logic [0:0]  CSR_BLOCK_LENGTH = 1'b0;
   localparam logic [0:0]  CSR_TOKEN_TRIES  = 1'b1;

   // Status codes on the result channel
   typedef enum logic [1:0] {
      STATUS_NONE    = 2'd0,
      STATUS_OK      = 2'd1,
      STATUS_CRC_ERR = 2'd2,
      STATUS_TIMEOUT = 2'd3
   } status_type;

   // Receive phases
   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_DATA   = 2'd1,
      PH_CRC_HI = 2'd2,
      PH_CRC_LO = 2'd3
   } phase_type;

   // Configuration as seen by the framing logic
   typedef struct packed {
      logic [9:0]  block_length;
      logic [15:0] token_tries;
   } cfg_type;

   // Registered input item handed to the framing logic
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } item_type;

   // CRC-16, MSB first, one byte per call
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/sdrx_req_if.sv =====
// Interface: input channel carrying one received byte per item.
`default_nettype none

interface sdrx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/sdrx_rsp_if.sv =====
// Interface: result channel carrying payload bytes and block status.
`default_nettype none

interface sdrx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       data_valid;
   logic       last_data;
   logic [1:0] status;

   modport source (output valid, output data_byte, output data_valid,
                   output last_data, output status, input ready);
   modport sink   (input valid, input data_byte, input data_valid,
                   input last_data, input status, output ready);
endinterface

`default_nettype wire

// ===== design/sdrx_csr.sv =====
// Configuration registers: block length and start token tries.
`default_nettype none

module sdrx_csr (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire  [0:0]         csr_index,
   input  wire  [15:0]        csr_wdata,
   output sdrx_pkg::cfg_type  cfg
);
   import sdrx_pkg::*;

   logic [9:0]  block_length_ff, block_length_in;
   logic [15:0] token_tries_ff, token_tries_in;

   // Register write decode
   always_comb begin
      block_length_in = block_length_ff;
      token_tries_in  = token_tries_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_LENGTH: block_length_in = csr_wdata[9:0];
            CSR_TOKEN_TRIES:  token_tries_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= BLOCK_LENGTH_RESET;
         token_tries_ff  <= TOKEN_TRIES_RESET;
      end else begin
         block_length_ff <= block_length_in;
         token_tries_ff  <= token_tries_in;
      end
   end

   assign cfg.block_length = block_length_ff;
   assign cfg.token_tries  = token_tries_ff;

endmodule

`default_nettype wire

// ===== design/sdrx_in_reg.sv =====
// Input register: captures one item and holds it until the framing logic takes it.
`default_nettype none

module sdrx_in_reg (
   input  wire                 clock,
   input  wire                 reset,
   sdrx_req_if.sink            req,
   input  wire                 take,
   output sdrx_pkg::item_type  item
);
   import sdrx_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       req_fire;

   // Free slot when empty or when the held item leaves this cycle
   assign req.ready = !valid_ff || take;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         byte_in  = req.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

`default_nettype wire

// ===== design/sdrx_core.sv =====
// Framing logic: token hunt, payload count, CRC check and the result register.
`default_nettype none

module sdrx_core (
   input  wire                 clock,
   input  wire                 reset,
   input  sdrx_pkg::cfg_type   cfg,
   input  sdrx_pkg::item_type  item,
   output logic                take,
   sdrx_rsp_if.source          rsp
);
   import sdrx_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] wait_ff, wait_in;
   logic [9:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  data_byte_ff, data_byte_in;
   logic        data_valid_ff, data_valid_in;
   logic        last_data_ff, last_data_in;
   status_type  status_ff, status_in;

   logic        advance;
   logic        has_result;
   logic [7:0]  b;
   logic [15:0] wait_inc;
   logic [9:0]  count_inc;
   logic [9:0]  eff_len;
   logic        last;

   // Item moves on when the result register is free or drains this cycle
   assign advance = !rsp_valid_ff || rsp.ready;
   assign take    = item.valid && advance;

   assign b         = item.rx_byte;
   assign wait_inc  = wait_ff + 16'd1;
   assign count_inc = count_ff + 10'd1;

   // Block length saturated to 1..MAX_BLOCK
   always_comb begin
      if (cfg.block_length == 10'd0) begin
         eff_len = 10'd1;
      end else if (cfg.block_length > MAX_BLOCK) begin
         eff_len = MAX_BLOCK;
      end else begin
         eff_len = cfg.block_length;
      end
   end

   assign last = (count_inc >= eff_len);

   // Next state and result
   always_comb begin
      phase_in      = phase_ff;
      wait_in       = wait_ff;
      count_in      = count_ff;
      crc_in        = crc_ff;
      crc_high_in   = crc_high_ff;
      has_result    = 1'b0;
      data_byte_in  = 8'h00;
      data_valid_in = 1'b0;
      last_data_in  = 1'b0;
      status_in     = STATUS_NONE;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (b == START_TOKEN) begin
                  phase_in = PH_DATA;
                  wait_in  = 16'd0;
                  count_in = 10'd0;
                  crc_in   = 16'd0;
               end else if (wait_inc >= cfg.token_tries || wait_inc == 16'd0) begin
                  wait_in    = 16'd0;
                  has_result = 1'b1;
                  status_in  = STATUS_TIMEOUT;
               end else begin
                  wait_in = wait_inc;
               end
            end
            PH_DATA: begin
               crc_in        = crc_byte(crc_ff, b);
               count_in      = count_inc;
               has_result    = 1'b1;
               data_byte_in  = b;
               data_valid_in = 1'b1;
               last_data_in  = last;
               if (last) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               crc_high_in = b;
               phase_in    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               phase_in   = PH_HUNT;
               wait_in    = 16'd0;
               has_result = 1'b1;
               status_in  = ({crc_high_ff, b} == crc_ff) ? STATUS_OK : STATUS_CRC_ERR;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Result register valid: loads when the pipeline moves, else holds
   assign rsp_valid_in = advance ? has_result : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         wait_ff      <= 16'd0;
         count_ff     <= 10'd0;
         crc_ff       <= 16'd0;
         crc_high_ff  <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         crc_high_ff  <= crc_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         data_byte_ff  <= data_byte_in;
         data_valid_ff <= data_valid_in;
         last_data_ff  <= last_data_in;
         status_ff     <= status_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.data_byte  = data_byte_ff;
   assign rsp.data_valid = data_valid_ff;
   assign rsp.last_data  = last_data_ff;
   assign rsp.status     = status_ff;

endmodule

`default_nettype wire

// ===== design/sd_data_block_receive_crc16.sv =====
// Top level: SD card SPI-mode data block receiver with CRC-16 check.
//
// Takes one received byte per item, hunts for the 0xFE start token (timeout
// status after token_tries bytes), forwards block_length (saturated to
// 1..512) payload bytes with last_data on the final one, then checks the
// big-endian CRC-16 (poly 0x1021, init 0) and gives status ok or crc error.
// One item is accepted every clock cycle while the result channel does not
// stall; a byte passes an input register and the byte-wide CRC update into
// the result register. Token, CRC high byte and non-timeout hunt bytes give
// no result. A stalled result channel stalls input after one further item.
`default_nettype none

module sd_data_block_receive_crc16 (
   input  wire          clock,
   input  wire          reset,
   sdrx_req_if.sink     req_if,
   sdrx_rsp_if.source   rsp_if,
   input  wire          csr_wr_en,
   input  wire  [0:0]   csr_index,
   input  wire  [15:0]  csr_wdata
);
   import sdrx_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     take;

   sdrx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdrx_in_reg u_in_reg (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .take  (take),
      .item  (item)
   );

   sdrx_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .item  (item),
      .take  (take),
      .rsp   (rsp_if)
   );

   // Payload bytes never carry a block status
   a_data_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data_valid |-> rsp_if.status == STATUS_NONE)
      else $error("payload item with non-zero status");

   // Last marker only on payload bytes
   a_last_on_data: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.last_data |-> rsp_if.data_valid)
      else $error("last_data without data_valid");

   // Status items carry a zero data byte
   a_status_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.data_valid |-> rsp_if.data_byte == 8'h00)
      else $error("status item with non-zero data byte");

   // Input back-pressure only arises from a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid && !rsp_if.ready)
      else $error("input stalled while result side is free");

endmodule

`default_nettype wire

// ===== tb/sv/sdrx_block_checker.sv =====
`timescale 1ns / 100ps
// Checker: predicts the SD block receiver's results from accepted bytes and compares them.
module sdrx_block_checker (
   input  wire          clock,
   input  wire          reset,
   sdrx_req_if          req,
   sdrx_rsp_if          rsp,
   input  wire          csr_wr_en,
   input  wire  [0:0]   csr_index,
   input  wire  [15:0]  csr_wdata,
   output int unsigned  fail_count,
   output int unsigned  pending
);
   import sdrx_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_valid;
      logic       last_data;
      status_type status;
   } block_result_type;

   // results still owed by the block, oldest first
   block_result_type expected_q[$];

   // receive state as the predictor tracks it
   phase_type   rx_phase;
   logic [15:0] hunt_count;
   logic [9:0]  payload_count;
   logic [15:0] crc_run;
   logic [7:0]  crc_hi_byte;
   logic [9:0]  cfg_block_length;
   logic [15:0] cfg_token_tries;

   // CRC-16/XMODEM, one input bit at a time, MSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   // length register saturated to 1..MAX_BLOCK
   function automatic logic [9:0] used_length(input logic [9:0] reg_value);
      if (reg_value == 10'd0) return 10'd1;
      if (reg_value > MAX_BLOCK) return MAX_BLOCK;
      return reg_value;
   endfunction

   // advance the receive state by one byte, queue any result it causes
   task automatic predict_byte(input logic [7:0] b);
      block_result_type r;
      r = '0;
      case (rx_phase)
         PH_HUNT: begin
            if (b == START_TOKEN) begin
               rx_phase      = PH_DATA;
               hunt_count    = '0;
               payload_count = '0;
               crc_run       = '0;
            end else begin
               hunt_count = hunt_count + 16'd1;
               if (hunt_count >= cfg_token_tries || hunt_count == 16'd0) begin
                  hunt_count = '0;
                  r.status   = STATUS_TIMEOUT;
                  expected_q.push_back(r);
               end
            end
         end
         PH_DATA: begin
            crc_run       = crc16_step(crc_run, b);
            payload_count = payload_count + 10'd1;
            r.data_byte   = b;
            r.data_valid  = 1'b1;
            r.last_data   = (payload_count >= used_length(cfg_block_length));
            r.status      = STATUS_NONE;
            if (r.last_data) rx_phase = PH_CRC_HI;
            expected_q.push_back(r);
         end
         PH_CRC_HI: begin
            crc_hi_byte = b;
            rx_phase    = PH_CRC_LO;
         end
         default: begin
            rx_phase   = PH_HUNT;
            hunt_count = '0;
            if ({crc_hi_byte, b} == crc_run) r.status = STATUS_OK;
            else r.status = STATUS_CRC_ERR;
            expected_q.push_back(r);
         end
      endcase
   endtask

   // items in first, then register writes, then results out
   always @(posedge clock) begin : watch_channels
      block_result_type got;
      block_result_type want;
      if (reset) begin
         expected_q.delete();
         rx_phase         = PH_HUNT;
         hunt_count       = '0;
         payload_count    = '0;
         crc_run          = '0;
         crc_hi_byte      = '0;
         cfg_block_length = BLOCK_LENGTH_RESET;
         cfg_token_tries  = TOKEN_TRIES_RESET;
         fail_count       = 0;
      end else begin
         if (req.valid && req.ready) predict_byte(req.rx_byte);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BLOCK_LENGTH: cfg_block_length = csr_wdata[9:0];
               CSR_TOKEN_TRIES:  cfg_token_tries  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got.data_byte  = rsp.data_byte;
            got.data_valid = rsp.data_valid;
            got.last_data  = rsp.last_data;
            got.status     = status_type'(rsp.status);
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: byte %02h valid %0d last %0d status %0d",
                           got.data_byte, got.data_valid, got.last_data, got.status);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected byte %02h valid %0d last %0d status %0d, %s",
                              want.data_byte, want.data_valid, want.last_data, want.status,
                              $sformatf("got byte %02h valid %0d last %0d status %0d",
                                        got.data_byte, got.data_valid, got.last_data,
                                        got.status));
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top: drives bytes and register writes into the SD block receiver and gives the verdict.
module tb_top;
   import sdrx_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;
   int unsigned fail_count;
   int unsigned pending;

   bit          src_calm     = 1'b0;
   bit          sink_calm    = 1'b0;
   int          holds_wanted = 0;
   int          holds_done   = 0;
   int          items_sent   = 0;
   logic [7:0]  frame_bytes[$];

   sdrx_req_if req_if ();
   sdrx_rsp_if rsp_if ();

   sd_data_block_receive_crc16 dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sdrx_block_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // idle cycles before the next item on either side
   function automatic int pick_gap(input bit calm);
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(1, 12);
   endfunction

   // offer one byte and hold it until the block takes it
   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(src_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // stop offering, let all owed results out, then allow for silent bytes in flight
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // token, frame_bytes as payload, then the CRC with crc_flip xored in
   task automatic send_frame(input logic [15:0] crc_flip);
      logic [15:0] crc;
      crc = 16'h0000;
      push_byte(START_TOKEN);
      foreach (frame_bytes[i]) begin
         crc = crc_byte(crc, frame_bytes[i]);
         push_byte(frame_bytes[i]);
      end
      crc = crc ^ crc_flip;
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
   endtask

   // result side: random stalls, one long hold-off when asked
   initial begin : result_sink
      int gap;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (holds_done < holds_wanted) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end
         gap = pick_gap(sink_calm);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin : stimulus
      logic [15:0] crc;
      logic [9:0]  len_reg;
      logic [15:0] tries_reg;
      logic [15:0] flip;
      int          eff;
      int          n_frames;
      int          n_noise;
      int          shape;
      bit          first_phase;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_BLOCK_LENGTH;
      csr_wdata      <= 16'h0000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short blocks, quick timeout
      write_csr(CSR_BLOCK_LENGTH, 16'd4);
      write_csr(CSR_TOKEN_TRIES, 16'd3);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h5A);
      frame_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
      send_frame(16'h0000);
      // token value inside the payload, low CRC byte wrong
      frame_bytes = '{8'hFE, 8'h01, 8'hFE, 8'h01};
      send_frame(16'h0001);
      // high CRC byte wrong
      frame_bytes = '{8'hAA, 8'h55, 8'h0F, 8'hF0};
      send_frame(16'h8000);
      settle();

      // zero tries: every stray byte times out
      write_csr(CSR_TOKEN_TRIES, 16'd0);
      push_byte(8'hEE);
      push_byte(8'h01);
      settle();

      // zero length saturates to one byte; largest tries
      write_csr(CSR_BLOCK_LENGTH, 16'd0);
      write_csr(CSR_TOKEN_TRIES, 16'hFFFF);
      frame_bytes = '{8'hC3};
      send_frame(16'h0000);
      settle();

      // length shortened below the count mid-block: next payload byte is the last
      write_csr(CSR_BLOCK_LENGTH, 16'd8);
      frame_bytes = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};
      crc = 16'h0000;
      push_byte(START_TOKEN);
      for (int i = 0; i < 6; i++) begin
         if (i == 5) begin
            settle();
            write_csr(CSR_BLOCK_LENGTH, 16'd3);
         end
         crc = crc_byte(crc, frame_bytes[i]);
         push_byte(frame_bytes[i]);
      end
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);

      // random phases: new settings, then a few frames with some noise
      first_phase = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         settle();
         shape = $urandom_range(0, 99);
         if (first_phase) len_reg = 10'd1023;
         else if (shape < 2) len_reg = 10'($urandom_range(512, 1023));
         else if (shape < 8) len_reg = 10'd0;
         else if (shape < 25) len_reg = 10'($urandom_range(1, 3));
         else len_reg = 10'($urandom_range(1, 16));
         eff = (len_reg == 10'd0) ? 1 : ((len_reg > MAX_BLOCK) ? int'(MAX_BLOCK) : int'(len_reg));

         shape = $urandom_range(0, 99);
         if (shape < 10) tries_reg = 16'd0;
         else if (shape < 15) tries_reg = 16'hFFFF;
         else if (shape < 20) tries_reg = TOKEN_TRIES_RESET;
         else tries_reg = 16'($urandom_range(1, 24));

         write_csr(CSR_BLOCK_LENGTH, {6'($urandom), len_reg});
         write_csr(CSR_TOKEN_TRIES, tries_reg);

         src_calm  = ($urandom_range(0, 3) == 0);
         sink_calm = ($urandom_range(0, 3) == 0);
         n_frames  = (eff > 16) ? 1 : $urandom_range(1, 4);

         // once: receiver holds off while the sender streams flat out
         if (holds_wanted == 0 && items_sent > 400 && eff <= 16) begin
            holds_wanted = 1;
            src_calm     = 1'b1;
            sink_calm    = 1'b0;
            n_frames     = 4;
         end

         repeat (n_frames) begin
            n_noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            repeat (n_noise) push_byte(8'($urandom));
            items_sent += n_noise;
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
               // broken frame: token and a random count of bytes
               n_noise = $urandom_range(1, eff + 2);
               push_byte(START_TOKEN);
               repeat (n_noise) push_byte(8'($urandom));
               items_sent += n_noise + 1;
            end else begin
               frame_bytes.delete();
               repeat (eff) frame_bytes.push_back(8'($urandom));
               shape = $urandom_range(0, 9);
               if (shape < 7) flip = 16'h0000;
               else if (shape < 9) flip = 16'h0001 << $urandom_range(0, 15);
               else flip = 16'($urandom_range(1, 65535));
               send_frame(flip);
               items_sent += eff + 3;
            end
         end
         first_phase = 1'b0;
      end

      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/sdrx_pkg.sv
design/sdrx_req_if.sv
design/sdrx_rsp_if.sv
design/sdrx_csr.sv
design/sdrx_in_reg.sv
design/sdrx_core.sv
design/sd_data_block_receive_crc16.sv
tb/sv/sdrx_block_checker.sv
tb/sv/tb_top.sv
